// File: hdl/udsn_pkg.sv
// Shared types and constants of the URI dot segment normalizer.
package udsn_pkg;

    // Default sizes, handed down from the top level
    localparam int MAX_URI_BYTES_DEF   = 64;
    localparam int SEG_STACK_DEPTH_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int QOFF_W = 7;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Class of one raw URI byte
    typedef enum logic [2:0] {
        CLS_SLASH,
        CLS_QUERY,
        CLS_DOT,
        CLS_TEXT,
        CLS_BAD
    } t_byte_class;

    // One classified byte as it waits in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] uri_byte;
        logic              final_byte;
        t_byte_class       cls;
    } t_item;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    // Dot class of the segment on top of the stack
    typedef enum logic [1:0] {
        DOT_EMPTY,
        DOT_ONE,
        DOT_TWO,
        DOT_TEXT
    } t_dot;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_SCAN,
        ST_FIN,
        ST_SEG,
        ST_BYTE,
        ST_ONE
    } t_back_state;

endpackage

// File: hdl/udsn_front.sv
// Front end: accepts raw URI bytes and classifies them into the queue.
module udsn_front
    import udsn_pkg::*;
(
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_uri_byte,
    input  logic              i_final_byte,
    input  t_queue_stat       i_qstat,
    output logic              o_in_ready,
    output logic              o_push,
    output t_item             o_item
);

    // Map a byte to its class; anything outside the allowed set is bad, NUL too
    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class c;
        unique case (b) inside
            8'h2F: c = CLS_SLASH;
            8'h3F: c = CLS_QUERY;
            8'h2E: c = CLS_DOT;
            [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
            8'h21, 8'h22, 8'h24, 8'h25, 8'h26, [8'h28:8'h2D],
            8'h3A, 8'h3B, 8'h3D, 8'h40, 8'h5F, 8'h7E: c = CLS_TEXT;
            default: c = CLS_BAD;
        endcase
        return c;
    endfunction

    // Take a transfer whenever the queue has room
    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    // Build the queue entry
    always_comb begin
        o_item.uri_byte   = i_uri_byte;
        o_item.final_byte = i_final_byte;
        o_item.cls        = classify(i_uri_byte);
    end

endmodule

// File: hdl/udsn_fifo.sv
// Short queue of classified bytes between the front and the back.
module udsn_fifo
    import udsn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    input  logic        i_pop,
    output t_item       o_item,
    output t_queue_stat o_qstat
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_fill;

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_fill == '0);
    assign o_qstat.full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/udsn_back.sv
// Back end: segment stack, byte store and emission of the normalized path.
module udsn_back
    import udsn_pkg::*;
#(
    parameter int MAX_URI_BYTES   = MAX_URI_BYTES_DEF,
    parameter int SEG_STACK_DEPTH = SEG_STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  t_queue_stat       i_qstat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_path_byte,
    output logic              o_end_of_path,
    output logic              o_uri_valid,
    output logic              o_query_present,
    output logic [QOFF_W-1:0] o_query_offset
);

    localparam int AW = $clog2(MAX_URI_BYTES);
    localparam int BW = $clog2(MAX_URI_BYTES + 1);
    localparam int SW = $clog2(SEG_STACK_DEPTH);
    localparam int CW = $clog2(SEG_STACK_DEPTH + 1);

    localparam logic [BW-1:0] BYTE_MAX = BW'(MAX_URI_BYTES);
    localparam logic [CW-1:0] SEG_MAX  = CW'(SEG_STACK_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [BW-1:0] LEN_ONE  = BW'(1);

    t_back_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [BW-1:0]     r_byte_count, n_byte_count;
    t_dot              r_dot, n_dot;
    logic              r_scanning, n_scanning;
    logic              r_still_valid, n_still_valid;
    logic [BW-1:0]     r_qs, n_qs;
    logic              r_saw, n_saw;
    logic [AW-1:0]     r_top_start, n_top_start;
    logic [BW-1:0]     r_top_len, n_top_len;
    logic [SW-1:0]     r_seg, n_seg;
    logic [BW-1:0]     r_len_left, n_len_left;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_path_byte, n_path_byte;
    logic              r_end, n_end;
    logic              r_uri_valid, n_uri_valid;
    logic              r_qp, n_qp;
    logic [QOFF_W-1:0] r_qo, n_qo;

    // Byte store and lower stack entries
    logic [BYTE_W-1:0]  r_byte_mem [MAX_URI_BYTES];
    logic [AW+BW-1:0]   r_seg_mem  [SEG_STACK_DEPTH];
    logic [BYTE_W-1:0]  r_rdata;
    logic [AW+BW-1:0]   r_seg_rd;

    logic               byte_we;
    logic [AW-1:0]      byte_wa;
    logic               seg_we;
    logic [SW-1:0]      seg_wa;
    logic [AW-1:0]      n_rd_addr;
    logic [SW-1:0]      n_seg_rd;

    logic               out_free;
    logic               is_last;
    logic [AW-1:0]      sel_start;
    logic [BW-1:0]      sel_len;
    logic [CW-1:0]      cnt_m1;
    logic               v_clear;

    assign out_free  = !r_out_valid || i_out_ready;
    assign cnt_m1    = r_count - CNT_ONE;
    assign is_last   = (r_seg == SW'(cnt_m1));
    assign sel_start = is_last ? r_top_start : r_seg_rd[AW+BW-1:BW];
    assign sel_len   = is_last ? r_top_len   : r_seg_rd[BW-1:0];
    assign byte_wa   = AW'(r_byte_count);
    assign seg_wa    = SW'(cnt_m1);

    // Next state, stack update and emission
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_byte_count  = r_byte_count;
        n_dot         = r_dot;
        n_scanning    = r_scanning;
        n_still_valid = r_still_valid;
        n_qs          = r_qs;
        n_saw         = r_saw;
        n_top_start   = r_top_start;
        n_top_len     = r_top_len;
        n_seg         = r_seg;
        n_len_left    = r_len_left;
        n_ptr         = r_ptr;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_path_byte   = r_path_byte;
        n_end         = r_end;
        n_uri_valid   = r_uri_valid;
        n_qp          = r_qp;
        n_qo          = r_qo;
        n_rd_addr     = r_ptr;
        n_seg_rd      = r_seg;
        o_pop         = 1'b0;
        byte_we       = 1'b0;
        seg_we        = 1'b0;
        v_clear       = 1'b0;

        unique case (r_state)
            ST_SCAN: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (r_still_valid) begin
                        if (r_byte_count >= BYTE_MAX) begin
                            n_still_valid = 1'b0;
                        end else begin
                            byte_we      = 1'b1;
                            n_byte_count = r_byte_count + 1'b1;
                            if (r_byte_count == '0 && i_item.cls != CLS_SLASH) begin
                                n_still_valid = 1'b0;
                            end else begin
                                case (i_item.cls)
                                    CLS_SLASH: begin
                                        if (r_scanning) begin
                                            // Resolve the top segment, then open a new one
                                            if (r_count == '0) begin
                                                n_count = CNT_ONE;
                                            end else if (r_dot == DOT_ONE) begin
                                                n_count = r_count;
                                            end else if (r_dot == DOT_TWO) begin
                                                if (r_count <= CNT_ONE) begin
                                                    n_still_valid = 1'b0;
                                                end else begin
                                                    n_count = cnt_m1;
                                                end
                                            end else if (r_count >= SEG_MAX) begin
                                                n_still_valid = 1'b0;
                                            end else begin
                                                seg_we  = 1'b1;
                                                n_count = r_count + 1'b1;
                                            end
                                            n_top_start = AW'(r_byte_count + 1'b1);
                                            n_top_len   = '0;
                                            n_dot       = DOT_EMPTY;
                                        end
                                    end
                                    CLS_QUERY: begin
                                        if (r_scanning) begin
                                            n_scanning = 1'b0;
                                            n_saw      = 1'b1;
                                            n_qs       = r_byte_count + 1'b1;
                                        end
                                    end
                                    CLS_BAD: begin
                                        n_still_valid = 1'b0;
                                    end
                                    default: begin
                                        if (r_scanning && r_count != '0) begin
                                            n_top_len = r_top_len + 1'b1;
                                            if (i_item.cls == CLS_DOT && r_dot != DOT_TEXT) begin
                                                n_dot = t_dot'(r_dot + 2'd1);
                                            end else begin
                                                n_dot = DOT_TEXT;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                    if (i_item.final_byte) begin
                        n_state = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                // Resolve a trailing dot segment into an empty final segment
                n_seg    = '0;
                n_seg_rd = '0;
                n_state  = ST_SEG;
                if (!r_still_valid || r_count == '0) begin
                    n_state = ST_ONE;
                end else if (r_dot == DOT_ONE) begin
                    n_top_len = '0;
                end else if (r_dot == DOT_TWO) begin
                    if (r_count <= CNT_ONE) begin
                        n_still_valid = 1'b0;
                        n_state       = ST_ONE;
                    end else begin
                        n_count   = cnt_m1;
                        n_top_len = '0;
                    end
                end
            end

            ST_SEG: begin
                // Emit the slash that opens a segment
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_path_byte = 8'h2F;
                    n_end       = (sel_len == '0) && is_last;
                    n_uri_valid = 1'b1;
                    n_qp        = r_saw;
                    n_qo        = QOFF_W'(r_qs);
                    n_len_left  = sel_len;
                    n_ptr       = sel_start;
                    n_rd_addr   = sel_start;
                    if (sel_len != '0) begin
                        n_state = ST_BYTE;
                    end else if (is_last) begin
                        v_clear = 1'b1;
                    end else begin
                        n_seg    = SW'(r_seg + 1'b1);
                        n_seg_rd = SW'(r_seg + 1'b1);
                    end
                end
            end

            ST_BYTE: begin
                // Emit stored segment bytes, one per transfer
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_path_byte = r_rdata;
                    n_end       = (r_len_left == LEN_ONE) && is_last;
                    n_uri_valid = 1'b1;
                    n_qp        = r_saw;
                    n_qo        = QOFF_W'(r_qs);
                    n_len_left  = r_len_left - 1'b1;
                    n_ptr       = r_ptr + 1'b1;
                    n_rd_addr   = r_ptr + 1'b1;
                    if (r_len_left == LEN_ONE) begin
                        if (is_last) begin
                            v_clear = 1'b1;
                        end else begin
                            n_seg    = SW'(r_seg + 1'b1);
                            n_seg_rd = SW'(r_seg + 1'b1);
                            n_state  = ST_SEG;
                        end
                    end
                end
            end

            ST_ONE: begin
                // Emit the single result of an invalid or empty path
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_path_byte = '0;
                    n_end       = 1'b1;
                    n_uri_valid = r_still_valid;
                    n_qp        = r_still_valid && r_saw;
                    n_qo        = r_still_valid ? QOFF_W'(r_qs) : '0;
                    v_clear     = 1'b1;
                end
            end

            default: begin
                n_state = ST_SCAN;
            end
        endcase

        // Drop all per URI state once the last result is out
        if (v_clear) begin
            n_state       = ST_SCAN;
            n_count       = '0;
            n_byte_count  = '0;
            n_dot         = DOT_EMPTY;
            n_scanning    = 1'b1;
            n_still_valid = 1'b1;
            n_qs          = '0;
            n_saw         = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SCAN;
            r_count       <= '0;
            r_byte_count  <= '0;
            r_dot         <= DOT_EMPTY;
            r_scanning    <= 1'b1;
            r_still_valid <= 1'b1;
            r_qs          <= '0;
            r_saw         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_byte_count  <= n_byte_count;
            r_dot         <= n_dot;
            r_scanning    <= n_scanning;
            r_still_valid <= n_still_valid;
            r_qs          <= n_qs;
            r_saw         <= n_saw;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top_start <= n_top_start;
        r_top_len   <= n_top_len;
        r_seg       <= n_seg;
        r_len_left  <= n_len_left;
        r_ptr       <= n_ptr;
        r_path_byte <= n_path_byte;
        r_end       <= n_end;
        r_uri_valid <= n_uri_valid;
        r_qp        <= n_qp;
        r_qo        <= n_qo;
    end

    // Byte store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_byte_mem[byte_wa] <= i_item.uri_byte;
        end
        r_rdata <= r_byte_mem[n_rd_addr];
    end

    // Segment stack below the top: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_seg_mem[seg_wa] <= {r_top_start, r_top_len};
        end
        r_seg_rd <= r_seg_mem[n_seg_rd];
    end

    assign o_out_valid     = r_out_valid;
    assign o_path_byte     = r_path_byte;
    assign o_end_of_path   = r_end;
    assign o_uri_valid     = r_uri_valid;
    assign o_query_present = r_qp;
    assign o_query_offset  = r_qo;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEG_MAX)
        else $error("segment count beyond stack depth");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= BYTE_MAX)
        else $error("byte count beyond store depth");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEG || r_state == ST_BYTE) |-> (r_still_valid && r_count != '0))
        else $error("path emission on an invalid or empty stack");

    a_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BYTE |-> r_len_left != '0)
        else $error("byte emission with no bytes left in segment");

    a_no_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_state == ST_SEG || r_state == ST_ONE))
        else $error("resolve step not followed by emission");
`endif

endmodule

// File: hdl/uri_path_dot_segment_normalizer.sv
// A byte is registered in the queue and scanned once the back end is in its scan state; after the
// final byte ST_FIN resolves the stack, and ST_SEG or ST_ONE loads the first result into the output register.
// Throughput: the scanner takes one byte per cycle from a 4-entry queue while in its scan state;
// emission gives one result per cycle while the output is free, one per normalized path byte.
// The time for a URI is set by one scan step per byte and one output transfer per result.
// Synchronous active-low reset clears control state only; stores need no clearing.
module uri_path_dot_segment_normalizer
    import udsn_pkg::*;
#(
    parameter int MAX_URI_BYTES   = MAX_URI_BYTES_DEF,
    parameter int SEG_STACK_DEPTH = SEG_STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_uri_byte,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_path_byte,
    output logic              o_end_of_path,
    output logic              o_uri_valid,
    output logic              o_query_present,
    output logic [QOFF_W-1:0] o_query_offset
);

    t_queue_stat qstat;
    t_item       push_item;
    t_item       pop_item;
    logic        push;
    logic        pop;

    // Classify incoming bytes
    udsn_front u_front (
        .i_in_valid   (i_in_valid),
        .i_uri_byte   (i_uri_byte),
        .i_final_byte (i_final_byte),
        .i_qstat      (qstat),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_item       (push_item)
    );

    // Decouple front and back
    udsn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_qstat (qstat)
    );

    // Normalize and emit
    udsn_back #(
        .MAX_URI_BYTES   (MAX_URI_BYTES),
        .SEG_STACK_DEPTH (SEG_STACK_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (pop_item),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_path_byte     (o_path_byte),
        .o_end_of_path   (o_end_of_path),
        .o_uri_valid     (o_uri_valid),
        .o_query_present (o_query_present),
        .o_query_offset  (o_query_offset)
    );

endmodule

// File: bench/udsn_path_checker.sv
// Scoreboard for the URI dot segment normalizer: predicts normalized path bytes and checks them.
module udsn_path_checker
    import udsn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_uri_byte,
    input  logic              i_final_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BYTE_W-1:0] i_path_byte,
    input  logic              i_end_of_path,
    input  logic              i_uri_valid,
    input  logic              i_query_present,
    input  logic [QOFF_W-1:0] i_query_offset,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic [BYTE_W-1:0] path_byte;
        logic              end_of_path;
        logic              uri_valid;
        logic              query_present;
        logic [QOFF_W-1:0] query_offset;
    } t_path_result;

    // Characters allowed anywhere in the URI besides slash and question mark
    string uri_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~%!$&\"()*+,;=:@";

    t_path_result path_expect_q[$];

    // Shadow copy of the scanner state
    logic [BYTE_W-1:0] uri_mem   [64];
    logic [5:0]        seg_begin [64];
    logic [6:0]        seg_len   [64];
    int unsigned       seg_cnt;
    int unsigned       byte_cnt;
    t_dot              dot;
    bit                in_path;
    bit                uri_ok;
    bit                has_query;
    int unsigned       qstart;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_scan();
        seg_cnt   = 0;
        byte_cnt  = 0;
        dot       = DOT_EMPTY;
        in_path   = 1'b1;
        uri_ok    = 1'b1;
        has_query = 1'b0;
        qstart    = 0;
    endtask

    function automatic bit char_allowed(logic [BYTE_W-1:0] b);
        if (b == '0)
            return 1'b0;
        for (int i = 0; i < uri_chars.len(); i++)
            if (uri_chars[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    // Fold a dot segment on top of the stack; 0 means the URI is invalid
    function automatic bit fold_dot_segment(bit at_end);
        if (seg_cnt == 0)
            return 1'b1;
        if (dot == DOT_ONE) begin
            if (at_end)
                seg_len[(seg_cnt - 1) % 64] = '0;
            else
                seg_cnt--;
        end else if (dot == DOT_TWO) begin
            if (seg_cnt <= 1)
                return 1'b0;
            if (at_end) begin
                seg_cnt--;
                seg_len[(seg_cnt - 1) % 64] = '0;
            end else begin
                seg_cnt -= 2;
            end
        end
        return 1'b1;
    endfunction

    task automatic scan_uri_byte(logic [BYTE_W-1:0] b);
        int unsigned pos;
        int unsigned top;
        pos = byte_cnt;
        if (pos >= MAX_URI_BYTES_DEF) begin
            uri_ok = 1'b0;
            return;
        end
        uri_mem[pos % 64] = b;
        byte_cnt = pos + 1;
        if (pos == 0 && b != CH_SLASH) begin
            uri_ok = 1'b0;
            return;
        end
        if (b == CH_SLASH) begin
            if (!in_path)
                return;
            if (!fold_dot_segment(1'b0) || seg_cnt >= SEG_STACK_DEPTH_DEF) begin
                uri_ok = 1'b0;
                return;
            end
            seg_begin[seg_cnt % 64] = 6'((pos + 1) % 64);
            seg_len[seg_cnt % 64]   = '0;
            seg_cnt++;
            dot = DOT_EMPTY;
        end else if (b == CH_QUERY) begin
            if (!in_path)
                return;
            in_path   = 1'b0;
            has_query = 1'b1;
            qstart    = pos + 1;
        end else if (!char_allowed(b)) begin
            uri_ok = 1'b0;
        end else if (in_path && seg_cnt > 0) begin
            top = (seg_cnt - 1) % 64;
            seg_len[top] = seg_len[top] + 7'd1;
            if (b == CH_DOT && dot != DOT_TEXT)
                dot = t_dot'(dot + 1);
            else
                dot = DOT_TEXT;
        end
    endtask

    // Advance the shadow scanner by one byte; on the final byte queue the path it yields
    task automatic predict_uri_byte(logic [BYTE_W-1:0] b, logic fin);
        t_path_result r;
        t_path_result held;
        bit           have_held;
        int unsigned  n;
        int unsigned  start;
        int unsigned  len;
        if (uri_ok)
            scan_uri_byte(b);
        if (!fin)
            return;
        if (uri_ok && !fold_dot_segment(1'b1))
            uri_ok = 1'b0;
        r = '0;
        if (!uri_ok) begin
            r.end_of_path = 1'b1;
            path_expect_q.push_back(r);
            clear_scan();
            return;
        end
        r.uri_valid     = 1'b1;
        r.query_present = has_query;
        r.query_offset  = has_query ? QOFF_W'(qstart) : '0;
        held      = '0;
        have_held = 1'b0;
        n         = 0;
        for (int unsigned s = 0; s < seg_cnt && s < 64; s++) begin
            start = seg_begin[s % 64];
            len   = seg_len[s % 64];
            for (int unsigned k = 0; k <= len && n < 64; k++) begin
                r.path_byte = (k == 0) ? CH_SLASH : uri_mem[(start + k - 1) % 64];
                if (have_held)
                    path_expect_q.push_back(held);
                held      = r;
                have_held = 1'b1;
                n++;
            end
        end
        if (have_held) begin
            held.end_of_path = 1'b1;
            path_expect_q.push_back(held);
        end else begin
            r.path_byte   = '0;
            r.end_of_path = 1'b1;
            path_expect_q.push_back(r);
        end
        clear_scan();
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_path_result();
        t_path_result want;
        if (path_expect_q.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, actual path_byte %0d",
                     $time, i_path_byte);
            o_fail_count++;
            return;
        end
        want = path_expect_q.pop_front();
        check_field("path_byte", want.path_byte, i_path_byte);
        check_field("end_of_path", want.end_of_path, i_end_of_path);
        check_field("uri_valid", want.uri_valid, i_uri_valid);
        check_field("query_present", want.query_present, i_query_present);
        check_field("query_offset", want.query_offset, i_query_offset);
    endtask

    // Check the output transfer first, then predict from the input transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            path_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_path_result();
            if (i_in_valid && i_in_ready)
                predict_uri_byte(i_uri_byte, i_final_byte);
        end
        o_pending = path_expect_q.size();
    end

endmodule

// File: bench/tb_uri_path_dot_segment_normalizer.sv
// Testbench top for the URI dot segment normalizer: drives directed and random URIs, gives verdict.
module tb_uri_path_dot_segment_normalizer;
    import udsn_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_uri_byte;
    logic              i_final_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_path_byte;
    logic              o_end_of_path;
    logic              o_uri_valid;
    logic              o_query_present;
    logic [QOFF_W-1:0] o_query_offset;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycle_cnt  = 0;

    string text_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~%!$&\"()*+,;=:@";

    logic [BYTE_W-1:0] uri_q[$];

    always #(CLK_HALF) i_clk = ~i_clk;

    uri_path_dot_segment_normalizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_uri_byte     (i_uri_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_path_byte    (o_path_byte),
        .o_end_of_path  (o_end_of_path),
        .o_uri_valid    (o_uri_valid),
        .o_query_present(o_query_present),
        .o_query_offset (o_query_offset)
    );

    udsn_path_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_uri_byte     (i_uri_byte),
        .i_final_byte   (i_final_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_path_byte    (o_path_byte),
        .i_end_of_path  (o_end_of_path),
        .i_uri_valid    (o_uri_valid),
        .i_query_present(o_query_present),
        .i_query_offset (o_query_offset),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("uri_path_dot_segment_normalizer test failed");
            $finish;
        end
    end

    task automatic push_string(string s);
        for (int i = 0; i < s.len(); i++)
            uri_q.push_back(s[i]);
    endtask

    // Append segment text, weighted toward dots so dot segments show up often
    task automatic push_text(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                uri_q.push_back(CH_DOT);
            else
                uri_q.push_back(text_chars[$urandom_range(0, text_chars.len() - 1)]);
        end
    endtask

    task automatic push_query(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       uri_q.push_back(CH_SLASH);
                1:       uri_q.push_back(CH_QUERY);
                default: push_text(1);
            endcase
        end
    endtask

    // Well-formed path with random segments and an optional query
    task automatic build_path_uri();
        uri_q.delete();
        repeat ($urandom_range(1, 6)) begin
            uri_q.push_back(CH_SLASH);
            case ($urandom_range(0, 5))
                0:       begin end
                1:       push_string(".");
                2:       push_string("..");
                default: push_text($urandom_range(1, 6));
            endcase
        end
        if ($urandom_range(0, 2) == 0) begin
            uri_q.push_back(CH_QUERY);
            push_query($urandom_range(0, 6));
        end
    endtask

    // Push the byte and segment limits
    task automatic build_long_uri();
        uri_q.delete();
        case ($urandom_range(0, 2))
            0: begin
                uri_q.push_back(CH_SLASH);
                push_text($urandom_range(60, 70));
            end
            1: begin
                repeat ($urandom_range(30, 34)) begin
                    uri_q.push_back(CH_SLASH);
                    if ($urandom_range(0, 3) == 0)
                        push_text(1);
                end
            end
            default: begin
                uri_q.push_back(CH_SLASH);
                push_text(62);
                uri_q.push_back(CH_QUERY);
            end
        endcase
    endtask

    // Raw random bytes, sometimes behind a leading slash
    task automatic build_noise_uri();
        int n;
        uri_q.delete();
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 0)
            uri_q.push_back(CH_SLASH);
        while (uri_q.size() < n)
            uri_q.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Send the queued URI byte by byte, marking the last one final
    task automatic send_uri();
        int gap;
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < uri_q.size(); i++) begin
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid   = 1'b1;
            i_uri_byte   = uri_q[i];
            i_final_byte = (i == uri_q.size() - 1);
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
        end
        items_sent += uri_q.size();
    endtask

    task automatic send_string(string s);
        uri_q.delete();
        push_string(s);
        send_uri();
    endtask

    // Output side: stall a random number of cycles before each transfer
    initial begin : out_side
        int stall;
        int calm;
        calm        = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0)
                    calm = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int kind;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_uri_byte   = '0;
        i_final_byte = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: dot folding, trailing dot, leading dot-dot, no slash, query, bad bytes
        send_string("/a/./b/../c");
        send_string("/.");
        send_string("/..");
        send_string("x");
        send_string("/?/?");
        uri_q.delete();
        uri_q.push_back(CH_SLASH);
        uri_q.push_back(8'hFF);
        send_uri();
        uri_q.delete();
        uri_q.push_back(CH_SLASH);
        uri_q.push_back(8'h00);
        send_uri();

        // Random: mostly well-formed paths, some limit cases and noise
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                build_path_uri();
            else if (kind == 7)
                build_long_uri();
            else
                build_noise_uri();
            send_uri();
        end
        i_in_valid = 1'b0;

        // Drain outstanding results, then give stray ones time to show up
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("uri_path_dot_segment_normalizer test passed");
        else
            $display("uri_path_dot_segment_normalizer test failed");
        $finish;
    end

endmodule

// File: uri_path_dot_segment_normalizer.f
hdl/udsn_pkg.sv
hdl/udsn_front.sv
hdl/udsn_fifo.sv
hdl/udsn_back.sv
hdl/uri_path_dot_segment_normalizer.sv
bench/udsn_path_checker.sv
bench/tb_uri_path_dot_segment_normalizer.sv
